@@ design/sbtp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbtp_pkg
// Shared types, codes and helpers for the shuffle-bag tile picker.
// ----------------------------------------------------------------------------
package sbtp_pkg;

  // Fixed field widths
  localparam int TILE_W     = 8;
  localparam int STATUS_W   = 2;
  localparam int MODE_W     = 2;
  localparam int DIV_W      = 9;
  localparam int RNG_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Modulo unit: quotient bits retired per cycle and steps per operation
  localparam int MOD_BITS_PER_CYC = 4;
  localparam int MOD_STEPS        = RNG_W / MOD_BITS_PER_CYC;
  localparam int MOD_CNT_W        = $clog2(MOD_STEPS);

  // Selection modes
  localparam logic [MODE_W-1:0] MODE_NONE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SINGLE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SHUFFLE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_NONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_TILE  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 2'd3;

  // Request into the modulo unit
  typedef struct packed {
    logic             start;
    logic [RNG_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } mod_req_t;

  // Response from the modulo unit
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] rem;
  } mod_rsp_t;

  // One xorshift32 step (13, 17, 5)
  function automatic logic [RNG_W-1:0] xs32_next(input logic [RNG_W-1:0] x);
    logic [RNG_W-1:0] v;
    v = x;
    v = v ^ (v << 13);
    v = v ^ (v >> 17);
    v = v ^ (v << 5);
    return v;
  endfunction

endpackage
`default_nettype wire

@@ design/sbtp_mod.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbtp_mod
// Iterative 32-bit by 9-bit remainder unit, four restoring steps a cycle.
// ----------------------------------------------------------------------------
module sbtp_mod (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire sbtp_pkg::mod_req_t req,
  output sbtp_pkg::mod_rsp_t    rsp
);

  logic [sbtp_pkg::RNG_W-1:0]     dvd_r, dvd_nxt;
  logic [sbtp_pkg::DIV_W-1:0]     dvs_r, dvs_nxt;
  logic [sbtp_pkg::DIV_W-1:0]     rem_r, rem_nxt;
  logic [sbtp_pkg::MOD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           run_r, run_nxt;
  logic                           done_r, done_nxt;

  logic [sbtp_pkg::RNG_W-1:0] dvd_v;
  logic [sbtp_pkg::DIV_W-1:0] rem_v;
  logic [sbtp_pkg::DIV_W:0]   trial;

  // Retire a group of dividend bits into the partial remainder
  always_comb begin
    dvd_v = dvd_r;
    rem_v = rem_r;
    trial = '0;
    for (int b = 0; b < sbtp_pkg::MOD_BITS_PER_CYC; b++) begin
      trial = {rem_v, dvd_v[sbtp_pkg::RNG_W-1]};
      dvd_v = dvd_v << 1;
      if (trial >= {1'b0, dvs_r}) begin
        rem_v = sbtp_pkg::DIV_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_v = trial[sbtp_pkg::DIV_W-1:0];
      end
    end
  end

  // Load on start, step while running, pulse done after the last step
  always_comb begin
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dvd_nxt = req.dividend;
      dvs_nxt = req.divisor;
      rem_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      dvd_nxt = dvd_v;
      rem_nxt = rem_v;
      cnt_nxt = cnt_r + sbtp_pkg::MOD_CNT_W'(1);
      if (cnt_r == sbtp_pkg::MOD_CNT_W'(sbtp_pkg::MOD_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

@@ design/shuffle_bag_tile_picker_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// shuffle_bag_tile_picker_top
// Draw-driven tile picker: fixed variant, or shuffled bag of tile indices.
// ----------------------------------------------------------------------------
// A draw is taken when start is high and busy is low; its result appears on
// out_status/out_tile_index with out_valid high for one cycle and must be
// taken then. A draw with in_draw low gives no result. Mode none, mode 3 and
// an empty atlas answer in the cycle after the draw. A shuffle-mode draw
// from a non-empty bag answers through the pop and emit states. A single-mode
// draw waits on the shared remainder unit (eight four-bit steps) and answers
// once the remainder is done. A shuffle-mode draw that finds the bag empty
// first refills it: it loads the bag memory, then runs the N-1 swap steps
// (each one generator step, a wait on the remainder unit, two bag reads and
// two bag writes), then the pop. busy stays high for the whole draw.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle;
// any write empties the bag.
// ----------------------------------------------------------------------------
module shuffle_bag_tile_picker_top #(
  parameter int MAX_TILES = 256
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // draw channel
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               in_draw,
  // result channel
  output logic                                    out_valid,
  output logic [sbtp_pkg::STATUS_W-1:0]           out_status,
  output logic [sbtp_pkg::TILE_W-1:0]             out_tile_index,
  // configuration
  input  wire logic                               cfg_we,
  input  wire logic [sbtp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sbtp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int CNT_W  = $clog2(MAX_TILES + 1);
  localparam int ADDR_W = $clog2(MAX_TILES);
  localparam logic [sbtp_pkg::DIV_W-1:0] MAX_N = sbtp_pkg::DIV_W'(MAX_TILES);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_FILL = 10'b00_0000_0010,
    S_RNG  = 10'b00_0000_0100,
    S_MOD  = 10'b00_0000_1000,
    S_RDJ  = 10'b00_0001_0000,
    S_SWI  = 10'b00_0010_0000,
    S_SWJ  = 10'b00_0100_0000,
    S_POP  = 10'b00_1000_0000,
    S_EMIT = 10'b01_0000_0000,
    S_SMOD = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [sbtp_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic [sbtp_pkg::DIV_W-1:0]  count_r, count_nxt;
  logic [sbtp_pkg::TILE_W-1:0] fixed_r, fixed_nxt;

  // bag and generator state
  logic [sbtp_pkg::RNG_W-1:0]  rng_r, rng_nxt;
  logic [CNT_W-1:0]            fill_r, fill_nxt;
  logic [ADDR_W-1:0]           idx_r, idx_nxt;
  logic [ADDR_W-1:0]           j_r, j_nxt;
  logic [sbtp_pkg::TILE_W-1:0] bi_r, bi_nxt;

  // result register
  logic                          out_valid_r, out_valid_nxt;
  logic [sbtp_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [sbtp_pkg::TILE_W-1:0]   out_tile_r, out_tile_nxt;

  // bag memory
  logic [sbtp_pkg::TILE_W-1:0] bag_mem [MAX_TILES];
  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr;
  logic [sbtp_pkg::TILE_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]           mem_raddr;
  logic [sbtp_pkg::TILE_W-1:0] rd_data_r;

  sbtp_pkg::mod_req_t mod_req;
  sbtp_pkg::mod_rsp_t mod_rsp;

  logic             accept;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] n_m1;
  logic [CNT_W-1:0] fill_m1;
  logic [sbtp_pkg::RNG_W-1:0] rng_step;

  // Clamp the tile count to the bag depth
  always_comb begin
    if (count_r > MAX_N) begin
      n_eff = CNT_W'(MAX_N);
    end else begin
      n_eff = count_r[CNT_W-1:0];
    end
  end

  assign n_m1     = n_eff - CNT_W'(1);
  assign fill_m1  = fill_r - CNT_W'(1);
  assign rng_step = sbtp_pkg::xs32_next(rng_r);
  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;

  sbtp_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    count_nxt      = count_r;
    fixed_nxt      = fixed_r;
    rng_nxt        = rng_r;
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    j_nxt          = j_r;
    bi_nxt         = bi_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_tile_nxt   = out_tile_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = sbtp_pkg::TILE_W'(idx_r);
    mem_raddr      = idx_r;
    mod_req        = '0;

    case (state_r)
      S_IDLE: begin
        if (accept && in_draw) begin
          if (mode_r != sbtp_pkg::MODE_SINGLE && mode_r != sbtp_pkg::MODE_SHUFFLE) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = sbtp_pkg::STAT_NONE;
            out_tile_nxt   = '0;
          end else if (n_eff == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = sbtp_pkg::STAT_EMPTY;
            out_tile_nxt   = '0;
          end else if (mode_r == sbtp_pkg::MODE_SINGLE) begin
            mod_req.start    = 1'b1;
            mod_req.dividend = sbtp_pkg::RNG_W'(fixed_r);
            mod_req.divisor  = sbtp_pkg::DIV_W'(n_eff);
            state_nxt        = S_SMOD;
          end else if (fill_r == '0) begin
            idx_nxt   = '0;
            state_nxt = S_FILL;
          end else begin
            state_nxt = S_POP;
          end
        end
      end

      // load 0..N-1 into the bag, then shuffle from the top entry down
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = sbtp_pkg::TILE_W'(idx_r);
        if (idx_r == n_m1[ADDR_W-1:0]) begin
          if (idx_r == '0) begin
            fill_nxt  = n_eff;
            state_nxt = S_POP;
          end else begin
            state_nxt = S_RNG;
          end
        end else begin
          idx_nxt = idx_r + ADDR_W'(1);
        end
      end

      // advance the generator and reduce it mod i+1; read entry i meanwhile
      S_RNG: begin
        rng_nxt          = rng_step;
        mod_req.start    = 1'b1;
        mod_req.dividend = rng_step;
        mod_req.divisor  = sbtp_pkg::DIV_W'(idx_r) + sbtp_pkg::DIV_W'(1);
        mem_raddr        = idx_r;
        state_nxt        = S_MOD;
      end

      S_MOD: begin
        mem_raddr = idx_r;
        if (mod_rsp.done) begin
          j_nxt     = mod_rsp.rem[ADDR_W-1:0];
          bi_nxt    = rd_data_r;
          state_nxt = S_RDJ;
        end
      end

      S_RDJ: begin
        mem_raddr = j_r;
        state_nxt = S_SWI;
      end

      // entry j lands in slot i
      S_SWI: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = rd_data_r;
        state_nxt = S_SWJ;
      end

      // old entry i lands in slot j; step down or finish the shuffle
      S_SWJ: begin
        mem_we    = 1'b1;
        mem_waddr = j_r;
        mem_wdata = bi_r;
        idx_nxt   = idx_r - ADDR_W'(1);
        if (idx_r == ADDR_W'(1)) begin
          fill_nxt  = n_eff;
          state_nxt = S_POP;
        end else begin
          state_nxt = S_RNG;
        end
      end

      // pop the last entry of the bag
      S_POP: begin
        mem_raddr = fill_m1[ADDR_W-1:0];
        fill_nxt  = fill_m1;
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = sbtp_pkg::STAT_TILE;
        out_tile_nxt   = rd_data_r;
        state_nxt      = S_IDLE;
      end

      S_SMOD: begin
        if (mod_rsp.done) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = sbtp_pkg::STAT_TILE;
          out_tile_nxt   = mod_rsp.rem[sbtp_pkg::TILE_W-1:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // configuration writes; each one empties the bag
    if (cfg_we) begin
      fill_nxt = '0;
      case (cfg_index)
        sbtp_pkg::CFG_MODE:  mode_nxt  = cfg_wdata[sbtp_pkg::MODE_W-1:0];
        sbtp_pkg::CFG_COUNT: count_nxt = cfg_wdata[sbtp_pkg::DIV_W-1:0];
        sbtp_pkg::CFG_FIXED: fixed_nxt = cfg_wdata[sbtp_pkg::TILE_W-1:0];
        sbtp_pkg::CFG_SEED: begin
          if (cfg_wdata == '0) begin
            rng_nxt = sbtp_pkg::RNG_W'(1);
          end else begin
            rng_nxt = cfg_wdata;
          end
        end
        default: fill_nxt = '0;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= sbtp_pkg::MODE_NONE;
      count_r     <= '0;
      fixed_r     <= '0;
      rng_r       <= sbtp_pkg::RNG_W'(1);
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      count_r     <= count_nxt;
      fixed_r     <= fixed_nxt;
      rng_r       <= rng_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    j_r          <= j_nxt;
    bi_r         <= bi_nxt;
    out_status_r <= out_status_nxt;
    out_tile_r   <= out_tile_nxt;
  end

  // Bag memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bag_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= bag_mem[mem_raddr];
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_tile_index = out_tile_r;

  // A valid tile always lies inside the clamped atlas
  a_tile_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == sbtp_pkg::STAT_TILE) |->
      ({1'b0, out_tile_index} < sbtp_pkg::DIV_W'(n_eff)))
    else $error("tile index outside atlas");

  // Non-tile results carry a zero index
  a_tile_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != sbtp_pkg::STAT_TILE) |-> (out_tile_index == '0))
    else $error("index nonzero without a tile");

  // The remainder unit only finishes while the sequencer waits on it
  a_mod_owner: assert property (@(posedge clk) disable iff (!rst_n)
    mod_rsp.done |-> (state_r == S_MOD || state_r == S_SMOD))
    else $error("remainder done outside a wait state");

  // The bag never holds more than its depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (sbtp_pkg::DIV_W'(fill_r) <= MAX_N))
    else $error("bag fill above depth");

endmodule
`default_nettype wire

@@ bench/shuffle_bag_tile_picker_top_tb.sv @@
// ----------------------------------------------------------------------------
// shuffle_bag_tile_picker_top_tb
// Self-checking bench for the shuffle-bag tile picker. A short table of
// directed draws and register writes covers the corner cases: reset state,
// unused mode, empty atlas, oversized tile count, zero seed, one-tile bag
// and extreme fixed variants. Random phases of register writes and draw
// bursts follow. A local bag and xorshift model predicts every result beat,
// and a monitor compares each beat with the oldest prediction.
// ----------------------------------------------------------------------------
module shuffle_bag_tile_picker_top_tb;

  localparam int BAG_DEPTH    = 256;
  localparam int DRAW_TARGET  = 1550;
  localparam int STALL_LIMIT  = 40000;
  localparam int DRAIN_CYCLES = 16;
  localparam int IDLE_PCT     = 25;
  localparam int CALM_FIRST   = 500;
  localparam int CALM_LAST    = 800;
  localparam int NUM_ROWS     = 30;

  // Mode code 3 has no meaning and must answer like mode none
  localparam logic [sbtp_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [sbtp_pkg::STATUS_W-1:0] status;
    logic [sbtp_pkg::TILE_W-1:0]   tile;
  } pick_t;

  // One row of the directed table: a register write or a draw
  typedef struct packed {
    logic                            is_cfg;
    logic [sbtp_pkg::CFG_IDX_W-1:0]  idx;
    logic [sbtp_pkg::CFG_DATA_W-1:0] data;
    logic                            draw;
    logic                            typed;
    pick_t                           pick;
  } step_t;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            start     = 1'b0;
  logic                            in_draw   = 1'b0;
  logic                            cfg_we    = 1'b0;
  logic [sbtp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sbtp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            busy;
  logic                            out_valid;
  logic [sbtp_pkg::STATUS_W-1:0]   out_status;
  logic [sbtp_pkg::TILE_W-1:0]     out_tile_index;

  // Local copy of the registers and of the bag state
  logic [sbtp_pkg::MODE_W-1:0]   sel_mode    = sbtp_pkg::MODE_NONE;
  logic [sbtp_pkg::DIV_W-1:0]    atlas_count = '0;
  logic [sbtp_pkg::TILE_W-1:0]   fixed_pick  = '0;
  logic [sbtp_pkg::RNG_W-1:0]    rng_state   = 32'd1;
  logic [sbtp_pkg::TILE_W-1:0]   bag_model [BAG_DEPTH];
  logic [sbtp_pkg::DIV_W-1:0]    bag_left    = '0;

  pick_t picks_due [$];
  int    errors      = 0;
  int    draws_done  = 0;
  int    stall_cnt   = 0;

  step_t dir_rows [0:NUM_ROWS-1] = '{
    '{1'b0, sbtp_pkg::CFG_MODE,  32'd0, 1'b1, 1'b1, '{sbtp_pkg::STAT_NONE,  8'd0}},
    '{1'b0, sbtp_pkg::CFG_MODE,  32'd0, 1'b0, 1'b0, '{sbtp_pkg::STAT_NONE,  8'd0}},
    '{1'b1, sbtp_pkg::CFG_MODE,  32'(sbtp_pkg::MODE_SINGLE), 1'b0, 1'b0,
      '{sbtp_pkg::STAT_NONE, 8'd0}},
    '{1'b0, sbtp_pkg::CFG_MODE,  32'd0, 1'b1, 1'b1, '{sbtp_pkg::STAT_EMPTY, 8'd0}},
    '{1'b1, sbtp_pkg::CFG_COUNT, 32'd256, 1'b0, 1'b0, '{sbtp_pkg::STAT_NONE, 8'd0}},
    '{1'b1, sbtp_pkg::CFG_FIXED, 32'd255, 1'b0, 1'b0, '{sbtp_pkg::STAT_NONE, 8'd0}},
    '{1'b0, sbtp_pkg::CFG_MODE,  32'd0, 1'b1, 1'b1, '{sbtp_pkg::STAT_TILE,  8'd255}},
    '{1'b1, sbtp_pkg::CFG_FIXED, 32'd0, 1'b0, 1'b0, '{sbtp_pkg::STAT_NONE,  8'd0}},
    '{1'b0, sbtp_pkg::CFG_MODE,  32'd0, 1'b1, 1'b1, '{sbtp_pkg::STAT_TILE,  8'd0}},
    '{1'b1, sbtp_pkg::CFG_COUNT, 32'd511, 1'b0, 1'b0, '{sbtp_pkg::STAT_NONE, 8'd0}},
    '{1'b1, sbtp_pkg::CFG_FIXED, 32'd255, 1'b0, 1'b0, '{sbtp_pkg::STAT_NONE, 8'd0}},
    '{1'b0, sbtp_pkg::CFG_MODE,  32'd0, 1'b1, 1'b1, '{sbtp_pkg::STAT_TILE,  8'd255}},
    '{1'b1, sbtp_pkg::CFG_COUNT, 32'd7, 1'b0, 1'b0, '{sbtp_pkg::STAT_NONE,  8'd0}},
    '{1'b0, sbtp_pkg::CFG_MODE,  32'd0, 1'b1, 1'b1, '{sbtp_pkg::STAT_TILE,  8'd3}},
    '{1'b1, sbtp_pkg::CFG_MODE,  32'(MODE_UNUSED), 1'b0, 1'b0,
      '{sbtp_pkg::STAT_NONE, 8'd0}},
    '{1'b0, sbtp_pkg::CFG_MODE,  32'd0, 1'b1, 1'b1, '{sbtp_pkg::STAT_NONE,  8'd0}},
    '{1'b1, sbtp_pkg::CFG_SEED,  32'd0, 1'b0, 1'b0, '{sbtp_pkg::STAT_NONE,  8'd0}},
    '{1'b1, sbtp_pkg::CFG_MODE,  32'(sbtp_pkg::MODE_SHUFFLE), 1'b0, 1'b0,
      '{sbtp_pkg::STAT_NONE, 8'd0}},
    '{1'b1, sbtp_pkg::CFG_COUNT, 32'd1, 1'b0, 1'b0, '{sbtp_pkg::STAT_NONE,  8'd0}},
    '{1'b0, sbtp_pkg::CFG_MODE,  32'd0, 1'b1, 1'b1, '{sbtp_pkg::STAT_TILE,  8'd0}},
    '{1'b0, sbtp_pkg::CFG_MODE,  32'd0, 1'b1, 1'b1, '{sbtp_pkg::STAT_TILE,  8'd0}},
    '{1'b1, sbtp_pkg::CFG_COUNT, 32'd3, 1'b0, 1'b0, '{sbtp_pkg::STAT_NONE,  8'd0}},
    '{1'b0, sbtp_pkg::CFG_MODE,  32'd0, 1'b1, 1'b0, '{sbtp_pkg::STAT_NONE,  8'd0}},
    '{1'b0, sbtp_pkg::CFG_MODE,  32'd0, 1'b1, 1'b0, '{sbtp_pkg::STAT_NONE,  8'd0}},
    '{1'b0, sbtp_pkg::CFG_MODE,  32'd0, 1'b1, 1'b0, '{sbtp_pkg::STAT_NONE,  8'd0}},
    '{1'b0, sbtp_pkg::CFG_MODE,  32'd0, 1'b1, 1'b0, '{sbtp_pkg::STAT_NONE,  8'd0}},
    '{1'b1, sbtp_pkg::CFG_SEED,  32'hFFFF_FFFF, 1'b0, 1'b0,
      '{sbtp_pkg::STAT_NONE, 8'd0}},
    '{1'b0, sbtp_pkg::CFG_MODE,  32'd0, 1'b1, 1'b0, '{sbtp_pkg::STAT_NONE,  8'd0}},
    '{1'b1, sbtp_pkg::CFG_COUNT, 32'd0, 1'b0, 1'b0, '{sbtp_pkg::STAT_NONE,  8'd0}},
    '{1'b0, sbtp_pkg::CFG_MODE,  32'd0, 1'b1, 1'b1, '{sbtp_pkg::STAT_EMPTY, 8'd0}}
  };

  shuffle_bag_tile_picker_top #(
    .MAX_TILES(BAG_DEPTH)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_draw       (in_draw),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_tile_index(out_tile_index),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror a register write; every write empties the bag
  function automatic void apply_cfg(input logic [sbtp_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [sbtp_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      sbtp_pkg::CFG_MODE:  sel_mode    = data[sbtp_pkg::MODE_W-1:0];
      sbtp_pkg::CFG_COUNT: atlas_count = data[sbtp_pkg::DIV_W-1:0];
      sbtp_pkg::CFG_FIXED: fixed_pick  = data[sbtp_pkg::TILE_W-1:0];
      sbtp_pkg::CFG_SEED:  rng_state   = (data == '0) ? 32'd1 : data;
      default: begin
      end
    endcase
    bag_left = '0;
  endfunction

  // Work out the answer to one draw and advance the bag state
  function automatic pick_t next_pick();
    pick_t                       r;
    int                          n;
    int                          i;
    int                          j;
    logic [sbtp_pkg::RNG_W-1:0]  x;
    logic [sbtp_pkg::TILE_W-1:0] t;
    r = '0;
    n = (atlas_count > BAG_DEPTH) ? BAG_DEPTH : int'(atlas_count);
    if (sel_mode == sbtp_pkg::MODE_SINGLE || sel_mode == sbtp_pkg::MODE_SHUFFLE) begin
      if (n == 0) begin
        r.status = sbtp_pkg::STAT_EMPTY;
      end else begin
        r.status = sbtp_pkg::STAT_TILE;
        if (sel_mode == sbtp_pkg::MODE_SINGLE) begin
          r.tile = sbtp_pkg::TILE_W'(fixed_pick % n);
        end else begin
          // Refill with 0..n-1, then swap downward from the top entry
          if (bag_left == '0) begin
            for (i = 0; i < n; i++)
              bag_model[i] = sbtp_pkg::TILE_W'(i);
            for (i = n - 1; i >= 1; i--) begin
              x = rng_state;
              x = x ^ (x << 13);
              x = x ^ (x >> 17);
              x = x ^ (x << 5);
              rng_state = x;
              j = int'(x % (i + 1));
              t = bag_model[i];
              bag_model[i] = bag_model[j];
              bag_model[j] = t;
            end
            bag_left = sbtp_pkg::DIV_W'(n);
          end
          bag_left = bag_left - 1'b1;
          r.tile = bag_model[bag_left[sbtp_pkg::TILE_W-1:0]];
        end
      end
    end
    return r;
  endfunction

  // Offer one beat, hold it until taken, then maybe drop start and idle
  task automatic send_draw(input logic d, input logic typed, input pick_t typed_pick,
                           input bit may_idle);
    pick_t p;
    int    gap;
    start   <= 1'b1;
    in_draw <= d;
    do @(posedge clk); while (busy);
    if (d) begin
      p = next_pick();
      picks_due.insert(picks_due.size(), typed ? typed_pick : p);
    end
    draws_done++;
    if (may_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      gap = $urandom_range(1, 8);
      start   <= 1'b0;
      in_draw <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
  endtask

  // Write one register once the block has drained and gone idle
  task automatic write_cfg(input logic [sbtp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sbtp_pkg::CFG_DATA_W-1:0] data);
    start <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    apply_cfg(idx, data);
    cfg_we <= 1'b0;
  endtask

  // Pick a register value, weighted toward small counts and extremes
  function automatic logic [sbtp_pkg::CFG_DATA_W-1:0] rand_reg(
      input logic [sbtp_pkg::CFG_IDX_W-1:0] idx);
    int                              r;
    logic [sbtp_pkg::CFG_DATA_W-1:0] v;
    r = $urandom_range(0, 99);
    v = $urandom();
    case (idx)
      sbtp_pkg::CFG_MODE: begin
        if (r < 10)      v[sbtp_pkg::MODE_W-1:0] = sbtp_pkg::MODE_NONE;
        else if (r < 15) v[sbtp_pkg::MODE_W-1:0] = MODE_UNUSED;
        else if (r < 40) v[sbtp_pkg::MODE_W-1:0] = sbtp_pkg::MODE_SINGLE;
        else             v[sbtp_pkg::MODE_W-1:0] = sbtp_pkg::MODE_SHUFFLE;
      end
      sbtp_pkg::CFG_COUNT: begin
        if (r < 3)       v[sbtp_pkg::DIV_W-1:0] = '0;
        else if (r < 80) v[sbtp_pkg::DIV_W-1:0] = sbtp_pkg::DIV_W'($urandom_range(1, 16));
        else if (r < 88) v[sbtp_pkg::DIV_W-1:0] = sbtp_pkg::DIV_W'($urandom_range(17, 255));
        else if (r < 94) v[sbtp_pkg::DIV_W-1:0] = sbtp_pkg::DIV_W'(BAG_DEPTH);
        else             v[sbtp_pkg::DIV_W-1:0] = sbtp_pkg::DIV_W'($urandom_range(257, 511));
      end
      sbtp_pkg::CFG_FIXED: begin
        if (r < 10)      v[sbtp_pkg::TILE_W-1:0] = '0;
        else if (r < 20) v[sbtp_pkg::TILE_W-1:0] = '1;
      end
      sbtp_pkg::CFG_SEED: begin
        if (r < 10)      v = '0;
        else if (r < 20) v = '1;
        else if (r < 25) v = 32'd1;
      end
      default: begin
      end
    endcase
    return v;
  endfunction

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    pick_t due;
    if (rst_n && out_valid) begin
      if (picks_due.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got status %0d tile %0d",
                 $time, out_status, out_tile_index);
        errors++;
      end else begin
        due = picks_due.pop_front();
        if (out_status !== due.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, due.status, out_status);
          errors++;
        end
        if (out_tile_index !== due.tile) begin
          $display("%0t: tile_index mismatch, expected %0d, got %0d",
                   $time, due.tile, out_tile_index);
          errors++;
        end
      end
    end
  end

  // Stop the run when no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    int                             burst;
    int                             n_eff;
    int                             k;
    bit                             wrote;
    bit                             calm;
    logic [sbtp_pkg::CFG_IDX_W-1:0] idx;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    for (k = 0; k < NUM_ROWS; k++) begin
      if (dir_rows[k].is_cfg)
        write_cfg(dir_rows[k].idx, dir_rows[k].data);
      else
        send_draw(dir_rows[k].draw, dir_rows[k].typed, dir_rows[k].pick, 1'b1);
    end

    // Random phases: reprogram some registers, then a burst of draws
    while (draws_done < DRAW_TARGET) begin
      wrote = 1'b0;
      for (k = 0; k < 4; k++) begin
        idx = sbtp_pkg::CFG_IDX_W'(k);
        if ($urandom_range(0, 1) == 1) begin
          write_cfg(idx, rand_reg(idx));
          wrote = 1'b1;
        end
      end
      if (!wrote)
        write_cfg(sbtp_pkg::CFG_MODE, rand_reg(sbtp_pkg::CFG_MODE));

      n_eff = (atlas_count > BAG_DEPTH) ? BAG_DEPTH : int'(atlas_count);
      burst = (n_eff <= 16) ? $urandom_range(1, 3 * n_eff + 3) : $urandom_range(1, 40);
      // Now and then run a large bag past its end
      if (sel_mode == sbtp_pkg::MODE_SHUFFLE && n_eff > 16 && $urandom_range(0, 3) == 0)
        burst = n_eff + $urandom_range(1, 20);
      for (k = 0; k < burst && draws_done < DRAW_TARGET; k++) begin
        calm = (draws_done >= CALM_FIRST) && (draws_done < CALM_LAST);
        send_draw(1'($urandom_range(0, 9) != 0), 1'b0, '0, !calm);
      end
    end

    // Drain outstanding results, then let the block settle
    start <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ sim.f @@
design/sbtp_pkg.sv
design/sbtp_mod.sv
design/shuffle_bag_tile_picker_top.sv
bench/shuffle_bag_tile_picker_top_tb.sv
